@@ rtl/ssnd_pkg.sv @@
// ============================================================================
// ssnd_pkg: shared types and constants for the seven-segment number display
// Request structures, digit constants and the segment encoding table.
// ============================================================================
package ssnd_pkg;

    // Input request: display number and signed value to show.
    typedef struct packed {
        logic [2:0]         display_select;
        logic signed [15:0] shown_value;
    } t_in_req;

    // Output request: one digit of one display.
    typedef struct packed {
        logic [3:0] digit_line;
        logic [1:0] segment_group;
        logic [6:0] segment_pattern;
        logic       last_digit;
    } t_out_req;

    // Stage 1 result: clamped magnitude with display routing.
    typedef struct packed {
        logic       neg;
        logic [9:0] val;
        logic [3:0] base_line;
        logic [1:0] group;
    } t_clamp;

    // Stage 2 result: hundreds digit and value divided by ten.
    typedef struct packed {
        logic       neg;
        logic [9:0] val;
        logic [3:0] hund;
        logic [6:0] q10;
        logic [3:0] base_line;
        logic [1:0] group;
    } t_quot;

    // Stage 3 result: the three decimal digits.
    typedef struct packed {
        logic       neg;
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] units;
        logic [3:0] base_line;
        logic [1:0] group;
    } t_digits;

    // Display numbers and segment groups.
    localparam logic [2:0] DISP_FIRST  = 3'd1;
    localparam logic [2:0] DISP_GRP0   = 3'd2;
    localparam logic [2:0] DISP_GRP1   = 3'd3;
    localparam logic [2:0] DISP_LAST   = 3'd5;
    localparam logic [1:0] GROUP_LOW   = 2'd0;
    localparam logic [1:0] GROUP_MID   = 2'd1;
    localparam logic [1:0] GROUP_HIGH  = 2'd2;

    // Clamp limits.
    localparam logic [9:0]  MAX_POS    = 10'd999;
    localparam logic [16:0] MAX_NEG    = 17'd99;

    // Reciprocal multipliers: x/100 = (x*41)>>12 and x/10 = (x*205)>>11,
    // both exact for x up to 1023.
    localparam logic [15:0] RECIP_100  = 16'd41;
    localparam int          SHIFT_100  = 12;
    localparam logic [17:0] RECIP_10   = 18'd205;
    localparam int          SHIFT_10   = 11;
    localparam logic [6:0]  TEN_7      = 7'd10;
    localparam logic [9:0]  TEN_10     = 10'd10;

    // Digit positions within one display.
    localparam logic [1:0] POS_HUNDREDS = 2'd0;
    localparam logic [1:0] POS_TENS     = 2'd1;
    localparam logic [1:0] POS_UNITS    = 2'd2;

    // Segment patterns, bit 0 is segment a.
    localparam logic [6:0] SEG_MINUS = 7'h40;
    localparam logic [6:0] SEG_BLANK = 7'h00;

    function automatic logic [6:0] seg_encode(input logic [3:0] digit);
        logic [6:0] pat;
        case (digit)
            4'd0:    pat = 7'h3F;
            4'd1:    pat = 7'h06;
            4'd2:    pat = 7'h5B;
            4'd3:    pat = 7'h4F;
            4'd4:    pat = 7'h66;
            4'd5:    pat = 7'h6D;
            4'd6:    pat = 7'h7D;
            4'd7:    pat = 7'h07;
            4'd8:    pat = 7'h7F;
            4'd9:    pat = 7'h6F;
            default: pat = SEG_BLANK;
        endcase
        return pat;
    endfunction

endpackage

@@ rtl/ssnd_clamp.sv @@
// ============================================================================
// ssnd_clamp: first pipeline stage
// Drops requests for absent displays, takes the magnitude, clamps it and
// works out the segment group and first digit line.
// ============================================================================
module ssnd_clamp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ssnd_pkg::t_in_req i_req,
    output logic              o_valid,
    input  logic              i_ready,
    output ssnd_pkg::t_clamp  o_data
);
    import ssnd_pkg::*;

    logic        r_valid;
    t_clamp      r_data;
    t_clamp      n_data;
    logic        w_disp_ok;
    logic [16:0] w_neg_mag;
    logic [2:0]  w_disp_m1;

    // The stage takes a new request whenever it is empty or being drained.
    assign o_ready   = !r_valid || i_ready;
    assign w_disp_ok = (i_req.display_select >= DISP_FIRST) &&
                       (i_req.display_select <= DISP_LAST);

    // Magnitude and clamp; the most negative value also lands above 99.
    assign w_neg_mag = 17'h10000 - {1'b0, i_req.shown_value};
    assign w_disp_m1 = i_req.display_select - DISP_FIRST;

    always_comb begin
        n_data.neg = i_req.shown_value[15];
        if (i_req.shown_value[15]) begin
            n_data.val = (w_neg_mag > MAX_NEG) ? MAX_NEG[9:0] : w_neg_mag[9:0];
        end else if (i_req.shown_value > $signed({6'd0, MAX_POS})) begin
            n_data.val = MAX_POS;
        end else begin
            n_data.val = i_req.shown_value[9:0];
        end
        n_data.base_line = {w_disp_m1, 1'b0} + {1'b0, w_disp_m1};
        if (i_req.display_select <= DISP_GRP0) begin
            n_data.group = GROUP_LOW;
        end else if (i_req.display_select == DISP_GRP1) begin
            n_data.group = GROUP_MID;
        end else begin
            n_data.group = GROUP_HIGH;
        end
    end

    // Stage register with its valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && w_disp_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/ssnd_split.sv @@
// ============================================================================
// ssnd_split: second and third pipeline stages
// Splits the clamped value into decimal digits with reciprocal multipliers:
// quotients by 100 and 10 first, then the digits by subtraction.
// ============================================================================
module ssnd_split (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ssnd_pkg::t_clamp  i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output ssnd_pkg::t_digits o_data
);
    import ssnd_pkg::*;

    logic        r_v2;
    logic        r_v3;
    t_quot       r_s2;
    t_digits     r_s3;
    t_quot       n_s2;
    t_digits     n_s3;
    logic        w_ready2;
    logic        w_ready3;
    logic [15:0] w_prod100;
    logic [17:0] w_prod10;
    logic [6:0]  w_tens;
    logic [9:0]  w_units;

    assign w_ready3 = !r_v3 || i_ready;
    assign w_ready2 = !r_v2 || w_ready3;
    assign o_ready  = w_ready2;

    // Stage 2: both quotients from independent constant multiplies.
    assign w_prod100 = 16'(i_data.val) * RECIP_100;
    assign w_prod10  = 18'(i_data.val) * RECIP_10;

    always_comb begin
        n_s2.neg       = i_data.neg;
        n_s2.val       = i_data.val;
        n_s2.hund      = w_prod100[SHIFT_100 +: 4];
        n_s2.q10       = w_prod10[SHIFT_10 +: 7];
        n_s2.base_line = i_data.base_line;
        n_s2.group     = i_data.group;
    end

    // Stage 3: remainders give the tens and units digits.
    assign w_tens  = r_s2.q10 - (7'(r_s2.hund) * TEN_7);
    assign w_units = r_s2.val - (10'(r_s2.q10) * TEN_10);

    always_comb begin
        n_s3.neg       = r_s2.neg;
        n_s3.hund      = r_s2.hund;
        n_s3.tens      = w_tens[3:0];
        n_s3.units     = w_units[3:0];
        n_s3.base_line = r_s2.base_line;
        n_s3.group     = r_s2.group;
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_ready2) begin
                r_v2 <= i_valid;
            end
            if (w_ready3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready2 && i_valid) begin
            r_s2 <= n_s2;
        end
        if (w_ready3 && r_v2) begin
            r_s3 <= n_s3;
        end
    end

    assign o_valid = r_v3;
    assign o_data  = r_s3;

    // The quotients and digits stay in decimal range.
    a_hund_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_s2.hund < 4'd10) && (r_s2.q10 < 7'd100))
        else $error("hundreds or tens quotient out of range");

    a_quot_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> ((7'(r_s2.hund) * TEN_7) <= r_s2.q10))
        else $error("quotient by ten below ten times hundreds");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (r_s3.tens < 4'd10) && (r_s3.units < 4'd10))
        else $error("tens or units digit out of range");

endmodule

@@ rtl/ssnd_serial.sv @@
// ============================================================================
// ssnd_serial: segment encoding and digit serialiser
// Encodes the three digits on load and hands them out one request per
// cycle while the receiver is ready, hundreds first, units last.
// ============================================================================
module ssnd_serial (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  ssnd_pkg::t_digits  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output ssnd_pkg::t_out_req o_req
);
    import ssnd_pkg::*;

    logic       r_busy;
    logic [1:0] r_pos;
    logic [6:0] r_pat0;
    logic [6:0] r_pat1;
    logic [6:0] r_pat2;
    logic [3:0] r_base;
    logic [1:0] r_group;
    logic       w_take;
    logic       w_last_take;
    logic       w_load;

    assign w_take      = r_busy && i_ready;
    assign w_last_take = w_take && (r_pos == POS_UNITS);
    assign o_ready     = !r_busy || w_last_take;
    assign w_load      = i_valid && o_ready;

    // Control: busy flag and digit position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= POS_HUNDREDS;
        end else if (w_load) begin
            r_busy <= 1'b1;
            r_pos  <= POS_HUNDREDS;
        end else if (w_last_take) begin
            r_busy <= 1'b0;
        end else if (w_take) begin
            r_pos  <= r_pos + 2'd1;
        end
    end

    // Payload: the three patterns, minus in front of a negative value.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_pat0  <= i_data.neg ? SEG_MINUS : seg_encode(i_data.hund);
            r_pat1  <= seg_encode(i_data.tens);
            r_pat2  <= seg_encode(i_data.units);
            r_base  <= i_data.base_line;
            r_group <= i_data.group;
        end
    end

    // Output selection by position.
    always_comb begin
        o_req.digit_line    = r_base + {2'd0, r_pos};
        o_req.segment_group = r_group;
        o_req.last_digit    = (r_pos == POS_UNITS);
        case (r_pos)
            POS_HUNDREDS: o_req.segment_pattern = r_pat0;
            POS_TENS:     o_req.segment_pattern = r_pat1;
            POS_UNITS:    o_req.segment_pattern = r_pat2;
            default:      o_req.segment_pattern = SEG_BLANK;
        endcase
    end

    assign o_valid = r_busy;

    // A digit taken before the units is followed by the next digit.
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && (r_pos != POS_UNITS)) |=>
            (r_busy && (r_pos == $past(r_pos) + 2'd1)))
        else $error("digit position did not advance");

    // A new display starts at the hundreds digit.
    a_load_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_busy && (r_pos == POS_HUNDREDS)))
        else $error("loaded display does not start at hundreds");

    // No new digits are loaded while earlier ones remain.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_pos != POS_UNITS)) |-> !o_ready)
        else $error("serialiser ready with digits still pending");

endmodule

@@ rtl/seven_segment_number_display_core.sv @@
// ============================================================================
// seven_segment_number_display_core: multiplexed display number formatter
// Turns a display number and signed value into three digit requests.
// ============================================================================
//
//  Channel  Direction  Handshake                  Request
//  input    in         i_in_valid / o_in_ready    i_in_req  (t_in_req)
//  output   out        o_out_valid / i_out_ready  o_out_req (t_out_req)
//
//  Each input request for displays 1 to 5 gives three output requests on
//  consecutive cycles while the output is ready; the serialiser takes the
//  next digits only when idle or as the last units digit is taken. Requests
//  for other displays are accepted and dropped at the first stage. The
//  hundreds digit is offered once its request has passed four register
//  stages: clamp, stages 2 and 3 and the serialiser. Synchronous active-low
//  reset empties every stage. A stall on the output fills the pipeline stage
//  by stage; nothing is lost or repeated.
//
module seven_segment_number_display_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ssnd_pkg::t_in_req  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ssnd_pkg::t_out_req o_out_req
);
    import ssnd_pkg::*;

    logic    w_c_valid;
    logic    w_c_ready;
    t_clamp  w_c_data;
    logic    w_d_valid;
    logic    w_d_ready;
    t_digits w_d_data;

    // Stage 1: clamp and routing.
    ssnd_clamp u_clamp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_req   (i_in_req),
        .o_valid (w_c_valid),
        .i_ready (w_c_ready),
        .o_data  (w_c_data)
    );

    // Stages 2 and 3: decimal digits.
    ssnd_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_c_valid),
        .o_ready (w_c_ready),
        .i_data  (w_c_data),
        .o_valid (w_d_valid),
        .i_ready (w_d_ready),
        .o_data  (w_d_data)
    );

    // Output: encoding and serialising.
    ssnd_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_d_valid),
        .o_ready (w_d_ready),
        .i_data  (w_d_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_req   (o_out_req)
    );

endmodule
